@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define SGW_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgw assertion failed");

// Next-cycle implication, disabled while rst is high
`define SGW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgw assertion failed");

`endif

@@ rtl/sgw_pkg.sv @@
// Package for the scaled glyph and fill LCD writer: op codes, register
// indexes, LCD command bytes and the 5x8 font table. No dependencies.
package sgw_pkg;

   localparam int COORD_BITS    = 16;
   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_COUNT   = 96;
   localparam int GLYPH_BITS    = 8 * GLYPH_COLUMNS;

   // Request kinds carried in req_tuser
   localparam logic [1:0] OP_GLYPH = 2'd0;
   localparam logic [1:0] OP_RECT  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_FONT_COLOR = 2'd0;
   localparam logic [1:0] CSR_BACK_COLOR = 2'd1;
   localparam logic [1:0] CSR_FONT_SCALE = 2'd2;

   // Job kinds
   localparam logic [1:0] KIND_IDLE  = 2'd0;
   localparam logic [1:0] KIND_GLYPH = 2'd1;
   localparam logic [1:0] KIND_RECT  = 2'd2;

   // LCD controller commands
   localparam logic [7:0] CMD_ROW_SET   = 8'h2A;
   localparam logic [7:0] CMD_COL_SET   = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

   // Printable code range of the font
   localparam logic [7:0] FIRST_CHAR = 8'h20;
   localparam logic [7:0] LAST_CHAR  = 8'h7F;

   // Header steps; the pixel phase follows the memory write command
   localparam logic [3:0] STEP_ROW_CMD    = 4'd0;
   localparam logic [3:0] STEP_ROW_S_HI   = 4'd1;
   localparam logic [3:0] STEP_ROW_S_LO   = 4'd2;
   localparam logic [3:0] STEP_ROW_E_HI   = 4'd3;
   localparam logic [3:0] STEP_ROW_E_LO   = 4'd4;
   localparam logic [3:0] STEP_COL_CMD    = 4'd5;
   localparam logic [3:0] STEP_COL_S_HI   = 4'd6;
   localparam logic [3:0] STEP_COL_S_LO   = 4'd7;
   localparam logic [3:0] STEP_COL_E_HI   = 4'd8;
   localparam logic [3:0] STEP_COL_E_LO   = 4'd9;
   localparam logic [3:0] STEP_MEM_CMD    = 4'd10;
   localparam logic [3:0] STEP_PIXELS     = 4'd11;

   typedef logic [COORD_BITS-1:0] coord_type;

   // One glyph per entry, column 0 in the top byte; bit 0 of a column is the top dot
   localparam logic [GLYPH_BITS-1:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0000070507,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0006090906
   };

endpackage

@@ rtl/scaled_glyph_and_fill_lcd_writer.sv @@
// Scaled glyph and rectangle fill writer: turns draw requests into the
// byte stream of an 8-bit parallel TFT controller. Depends on sgw_pkg.
//
// A request's result item, if any, is on rsp in the cycle after it is
// taken. Throughput: one request item per cycle while the output
// register is empty or its item is taken; req_tready follows rsp_tready.
// Reset (synchronous, active high) leaves the writer idle with no result
// pending, font_color 0xFFFF, back_color 0 and font_scale 1.
module scaled_glyph_and_fill_lcd_writer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_pos[15:0], y_pos[31:16], char_code[39:32], rect_width[55:40],
   // rect_height[71:56], fill_color[87:72]
   input  logic [87:0] req_tdata,
   // op[1:0]
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bus_byte[7:0]
   output logic [7:0]  rsp_tdata,
   // is_command[0], rejected[1]
   output logic [1:0]  rsp_tuser,
   // job_last
   output logic        rsp_tlast,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import sgw_pkg::*;

   // Request fields
   coord_type   x_pos, y_pos, rect_width, rect_height;
   logic [15:0] fill_color;
   logic [7:0]  char_code;
   logic [1:0]  op;

   assign x_pos       = req_tdata[15:0];
   assign y_pos       = req_tdata[31:16];
   assign char_code   = req_tdata[39:32];
   assign rect_width  = req_tdata[55:40];
   assign rect_height = req_tdata[71:56];
   assign fill_color  = req_tdata[87:72];
   assign op          = req_tuser;

   // Configuration registers
   logic [15:0] font_color_ff, back_color_ff;
   logic [3:0]  font_scale_ff;

   // Job state
   logic [1:0]            job_kind_ff, job_kind_in;
   logic [3:0]            setup_step_ff, setup_step_in;
   logic                  low_byte_next_ff, low_byte_next_in;
   logic                  empty_ff, empty_in;
   coord_type             row_start_ff, row_start_in, row_end_ff, row_end_in;
   coord_type             col_start_ff, col_start_in, col_end_ff, col_end_in;
   coord_type             span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [15:0]           pixel_color_ff, pixel_color_in;
   logic [GLYPH_BITS-1:0] glyph_row_ff, glyph_row_in;
   logic [2:0]            glyph_column_ff, glyph_column_in;
   logic [3:0]            row_repeat_ff, row_repeat_in;
   logic [2:0]            bit_index_ff, bit_index_in;
   logic [3:0]            dot_repeat_ff, dot_repeat_in;
   coord_type             outer_count_ff, outer_count_in;
   coord_type             inner_count_ff, inner_count_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_cmd_ff, rsp_cmd_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_rej_ff, rsp_rej_in;

   logic       accept, busy, in_range, done;
   logic [7:0] cur_column;
   logic [15:0] color;
   coord_type  scale_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign busy       = (job_kind_ff != KIND_IDLE);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_rej_ff, rsp_cmd_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign in_range   = (char_code >= FIRST_CHAR) && (char_code <= LAST_CHAR);
   assign scale_wide = {{(COORD_BITS-4){1'b0}}, font_scale_ff};
   assign cur_column = glyph_row_ff[GLYPH_BITS-1 -: 8];
   assign color      = (job_kind_ff == KIND_GLYPH)
                       ? (cur_column[bit_index_ff] ? font_color_ff : back_color_ff)
                       : pixel_color_ff;

   // Next state and result for the accepted item
   always_comb begin
      job_kind_in      = job_kind_ff;
      setup_step_in    = setup_step_ff;
      low_byte_next_in = low_byte_next_ff;
      empty_in         = empty_ff;
      row_start_in     = row_start_ff;
      row_end_in       = row_end_ff;
      col_start_in     = col_start_ff;
      col_end_in       = col_end_ff;
      span_x_in        = span_x_ff;
      span_y_in        = span_y_ff;
      pixel_color_in   = pixel_color_ff;
      glyph_row_in     = glyph_row_ff;
      glyph_column_in  = glyph_column_ff;
      row_repeat_in    = row_repeat_ff;
      bit_index_in     = bit_index_ff;
      dot_repeat_in    = dot_repeat_ff;
      outer_count_in   = outer_count_ff;
      inner_count_in   = inner_count_ff;
      done             = 1'b0;

      // drain the output register when taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_rej_in   = rsp_rej_ff;

      if (accept) begin
         if (op == OP_GLYPH || op == OP_RECT) begin
            if (busy) begin
               // reject a start while a job runs
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'h00;
               rsp_cmd_in   = 1'b0;
               rsp_last_in  = 1'b0;
               rsp_rej_in   = 1'b1;
            end else begin
               // latch the job and its address window
               setup_step_in    = STEP_ROW_CMD;
               low_byte_next_in = 1'b0;
               glyph_column_in  = 3'd0;
               row_repeat_in    = 4'd0;
               bit_index_in     = 3'd0;
               dot_repeat_in    = 4'd0;
               outer_count_in   = '0;
               inner_count_in   = '0;
               row_start_in     = y_pos;
               col_start_in     = x_pos;
               if (op == OP_GLYPH) begin
                  job_kind_in  = KIND_GLYPH;
                  span_x_in    = scale_wide;
                  span_y_in    = '0;
                  row_end_in   = y_pos + (scale_wide << 3) - coord_type'(1);
                  col_end_in   = x_pos + (scale_wide << 3) - (scale_wide << 1);
                  empty_in     = (font_scale_ff == 4'd0);
                  glyph_row_in = in_range ? FONT_ROM[7'(char_code - FIRST_CHAR)] : '0;
               end else begin
                  job_kind_in    = KIND_RECT;
                  span_x_in      = rect_width;
                  span_y_in      = rect_height;
                  pixel_color_in = fill_color;
                  row_end_in     = y_pos + rect_height - coord_type'(1);
                  col_end_in     = x_pos + rect_width - coord_type'(1);
                  empty_in       = (rect_width == '0) || (rect_height == '0);
               end
            end
         end else if (op == OP_TICK && busy) begin
            rsp_valid_in = 1'b1;
            rsp_rej_in   = 1'b0;
            rsp_cmd_in   = 1'b0;
            if (setup_step_ff < STEP_PIXELS) begin
               // header bytes
               case (setup_step_ff)
                  STEP_ROW_CMD: begin
                     rsp_byte_in = CMD_ROW_SET;
                     rsp_cmd_in  = 1'b1;
                  end
                  STEP_ROW_S_HI: rsp_byte_in = row_start_ff[15:8];
                  STEP_ROW_S_LO: rsp_byte_in = row_start_ff[7:0];
                  STEP_ROW_E_HI: rsp_byte_in = row_end_ff[15:8];
                  STEP_ROW_E_LO: rsp_byte_in = row_end_ff[7:0];
                  STEP_COL_CMD: begin
                     rsp_byte_in = CMD_COL_SET;
                     rsp_cmd_in  = 1'b1;
                  end
                  STEP_COL_S_HI: rsp_byte_in = col_start_ff[15:8];
                  STEP_COL_S_LO: rsp_byte_in = col_start_ff[7:0];
                  STEP_COL_E_HI: rsp_byte_in = col_end_ff[15:8];
                  STEP_COL_E_LO: rsp_byte_in = col_end_ff[7:0];
                  STEP_MEM_CMD: begin
                     rsp_byte_in = CMD_MEM_WRITE;
                     rsp_cmd_in  = 1'b1;
                  end
                  default: rsp_byte_in = col_end_ff[7:0];
               endcase
               setup_step_in = setup_step_ff + 4'd1;
               done = (setup_step_ff == STEP_MEM_CMD) && empty_ff;
            end else if (!low_byte_next_ff) begin
               // pixel MSB
               rsp_byte_in      = color[15:8];
               low_byte_next_in = 1'b1;
            end else begin
               // pixel LSB, then advance the pixel counters
               rsp_byte_in      = color[7:0];
               low_byte_next_in = 1'b0;
               if (job_kind_ff == KIND_GLYPH) begin
                  if ({1'b0, dot_repeat_ff} + 5'd1 < {1'b0, span_x_ff[3:0]}) begin
                     dot_repeat_in = dot_repeat_ff + 4'd1;
                  end else begin
                     dot_repeat_in = 4'd0;
                     bit_index_in  = bit_index_ff + 3'd1;
                     if (bit_index_ff == 3'd7) begin
                        if ({1'b0, row_repeat_ff} + 5'd1 < {1'b0, span_x_ff[3:0]}) begin
                           row_repeat_in = row_repeat_ff + 4'd1;
                        end else begin
                           row_repeat_in   = 4'd0;
                           glyph_column_in = glyph_column_ff + 3'd1;
                           glyph_row_in    = glyph_row_ff << 8;
                           done = (glyph_column_ff == 3'(GLYPH_COLUMNS - 1));
                        end
                     end
                  end
               end else begin
                  if ({1'b0, inner_count_ff} + 17'd1 < {1'b0, span_y_ff}) begin
                     inner_count_in = inner_count_ff + coord_type'(1);
                  end else begin
                     inner_count_in = '0;
                     outer_count_in = outer_count_ff + coord_type'(1);
                     done = ({1'b0, outer_count_ff} + 17'd1 >= {1'b0, span_x_ff});
                  end
               end
            end
            rsp_last_in = done;
            if (done) begin
               // return to idle with cleared counters
               job_kind_in      = KIND_IDLE;
               setup_step_in    = STEP_ROW_CMD;
               low_byte_next_in = 1'b0;
               glyph_column_in  = 3'd0;
               row_repeat_in    = 4'd0;
               bit_index_in     = 3'd0;
               dot_repeat_in    = 4'd0;
               outer_count_in   = '0;
               inner_count_in   = '0;
            end
         end
      end
   end

   // Control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         job_kind_ff      <= KIND_IDLE;
         setup_step_ff    <= STEP_ROW_CMD;
         low_byte_next_ff <= 1'b0;
         font_color_ff    <= 16'hFFFF;
         back_color_ff    <= 16'h0000;
         font_scale_ff    <= 4'd1;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         job_kind_ff      <= job_kind_in;
         setup_step_ff    <= setup_step_in;
         low_byte_next_ff <= low_byte_next_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FONT_COLOR: font_color_ff <= csr_data;
               CSR_BACK_COLOR: back_color_ff <= csr_data;
               CSR_FONT_SCALE: font_scale_ff <= csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   // Payload and counter registers
   always_ff @(posedge clock) begin
      empty_ff        <= empty_in;
      row_start_ff    <= row_start_in;
      row_end_ff      <= row_end_in;
      col_start_ff    <= col_start_in;
      col_end_ff      <= col_end_in;
      span_x_ff       <= span_x_in;
      span_y_ff       <= span_y_in;
      pixel_color_ff  <= pixel_color_in;
      glyph_row_ff    <= glyph_row_in;
      glyph_column_ff <= glyph_column_in;
      row_repeat_ff   <= row_repeat_in;
      bit_index_ff    <= bit_index_in;
      dot_repeat_ff   <= dot_repeat_in;
      outer_count_ff  <= outer_count_in;
      inner_count_ff  <= inner_count_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_cmd_ff      <= rsp_cmd_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_rej_ff      <= rsp_rej_in;
   end

endmodule

@@ rtl/sgw_checker.sv @@
// Port-level checks for the scaled glyph and fill LCD writer, bound to
// the top level. Depends on assert_macros.svh and sgw_pkg.
`include "assert_macros.svh"

module sgw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import sgw_pkg::*;

   // no result pending right after reset
   `SGW_ASSERT_IMPLY(a_idle_after_reset, clock, 1'b0, $past(reset), !rsp_tvalid)
   // hold a stalled result
   `SGW_ASSERT_NEXT(a_hold_stalled, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   // a rejection carries no byte, no command flag and no job end
   `SGW_ASSERT_IMPLY(a_reject_clean, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tlast && !rsp_tuser[0] && rsp_tdata == 8'h00)
   // command bytes are only the three window and write commands
   `SGW_ASSERT_IMPLY(a_cmd_codes, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == CMD_ROW_SET || rsp_tdata == CMD_COL_SET || rsp_tdata == CMD_MEM_WRITE)
   // an empty job ends on the memory write command
   `SGW_ASSERT_IMPLY(a_cmd_last, clock, reset, rsp_tvalid && rsp_tuser[0] && rsp_tlast, rsp_tdata == CMD_MEM_WRITE)

endmodule

bind scaled_glyph_and_fill_lcd_writer sgw_checker u_sgw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ test/tb_scaled_glyph_and_fill_lcd_writer.sv @@
// Self-checking bench for the scaled glyph and fill LCD writer: queues draw and
// tick requests, predicts every bus byte and compares it on the rsp stream.
// Depends on sgw_pkg and on the scaled_glyph_and_fill_lcd_writer RTL.
`timescale 1ns / 100ps

module tb_scaled_glyph_and_fill_lcd_writer;
   import sgw_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int BLANK_ROW     = GLYPH_COUNT;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 40;
   localparam int LIMIT_NS      = 1_000_000;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [7:0]  code;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] rgb;
      bit          wait_drain;
   } lcd_request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       cmd;
      logic       last;
      logic       rej;
   } lcd_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_FONT_COLOR;
   logic [15:0] csr_data   = '0;

   lcd_request_type draw_queue[$];
   lcd_byte_type    lcd_bytes_due[$];
   lcd_request_type cur_req;
   int errors = 0;
   int gap_left = 0, burst_left = 0;
   int hold_requests = 0, hold_served = 0, hold_left = 0, stall_cycle = 0;

   // Predicted writer state, reset values
   logic [15:0] fg_rgb    = 16'hFFFF;
   logic [15:0] bg_rgb    = 16'h0000;
   logic [3:0]  scale_reg = 4'd1;
   logic [1:0]  wr_kind   = KIND_IDLE;
   coord_type   org_x     = '0;
   coord_type   org_y     = '0;
   logic [15:0] fill_rgb  = '0;
   int ext_x = 0, ext_y = 0, hdr_step = 0, glyph_row = 0, glyph_col = 0;
   int line_rep = 0, dot_bit = 0, dot_rep = 0, rect_col = 0, rect_row = 0;
   bit lsb_pending = 1'b0;

   scaled_glyph_and_fill_lcd_writer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic restart_counters();
      hdr_step = 0; glyph_col = 0; line_rep = 0; dot_bit = 0;
      dot_rep = 0; rect_col = 0; rect_row = 0; lsb_pending = 1'b0;
   endtask

   // Work out the bus byte, if any, that one accepted request produces
   task automatic predict_lcd_bytes(input lcd_request_type rq);
      coord_type   row_e, col_e;
      logic [7:0]  out_byte, column_bits;
      logic [15:0] dot_rgb;
      logic        cmd, last;
      cmd = 1'b0;
      last = 1'b0;
      out_byte = '0;
      if (rq.op == OP_GLYPH || rq.op == OP_RECT) begin
         if (wr_kind != KIND_IDLE) begin
            lcd_bytes_due.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
            return;
         end
         restart_counters();
         org_x = rq.x_pos;
         org_y = rq.y_pos;
         if (rq.op == OP_GLYPH) begin
            wr_kind = KIND_GLYPH;
            ext_x = scale_reg;
            ext_y = 0;
            glyph_row = (rq.code >= FIRST_CHAR && rq.code <= LAST_CHAR) ?
                        int'(rq.code - FIRST_CHAR) : BLANK_ROW;
         end else begin
            wr_kind = KIND_RECT;
            ext_x = rq.width;
            ext_y = rq.height;
            fill_rgb = rq.rgb;
         end
         return;
      end
      if (rq.op != OP_TICK || wr_kind == KIND_IDLE) return;

      if (hdr_step < STEP_PIXELS) begin
         // address window header, end values wrap at the coordinate width
         if (wr_kind == KIND_GLYPH) begin
            row_e = coord_type'(org_y + 8 * ext_x - 1);
            col_e = coord_type'(org_x + 6 * ext_x);
         end else begin
            row_e = coord_type'(org_y + ext_y - 1);
            col_e = coord_type'(org_x + ext_x - 1);
         end
         case (hdr_step)
            STEP_ROW_CMD: begin out_byte = CMD_ROW_SET; cmd = 1'b1; end
            STEP_ROW_S_HI: out_byte = org_y[15:8];
            STEP_ROW_S_LO: out_byte = org_y[7:0];
            STEP_ROW_E_HI: out_byte = row_e[15:8];
            STEP_ROW_E_LO: out_byte = row_e[7:0];
            STEP_COL_CMD: begin out_byte = CMD_COL_SET; cmd = 1'b1; end
            STEP_COL_S_HI: out_byte = org_x[15:8];
            STEP_COL_S_LO: out_byte = org_x[7:0];
            STEP_COL_E_HI: out_byte = col_e[15:8];
            STEP_COL_E_LO: out_byte = col_e[7:0];
            default: begin out_byte = CMD_MEM_WRITE; cmd = 1'b1; end
         endcase
         hdr_step++;
         // an empty job ends on the memory write command
         if (hdr_step == STEP_PIXELS)
            last = (wr_kind == KIND_GLYPH) ? (ext_x == 0) : (ext_x == 0 || ext_y == 0);
      end else begin
         if (wr_kind == KIND_GLYPH) begin
            column_bits = (glyph_row >= BLANK_ROW || glyph_col >= GLYPH_COLUMNS) ? 8'h00 :
                          FONT_ROM[glyph_row][GLYPH_BITS - 1 - 8 * glyph_col -: 8];
            dot_rgb = column_bits[dot_bit] ? fg_rgb : bg_rgb;
         end else begin
            dot_rgb = fill_rgb;
         end
         if (!lsb_pending) begin
            out_byte = dot_rgb[15:8];
            lsb_pending = 1'b1;
         end else begin
            out_byte = dot_rgb[7:0];
            lsb_pending = 1'b0;
            // step to the next pixel once its low byte is out
            if (wr_kind == KIND_GLYPH) begin
               dot_rep++;
               if (dot_rep >= ext_x) begin
                  dot_rep = 0;
                  dot_bit++;
                  if (dot_bit >= 8) begin
                     dot_bit = 0;
                     line_rep++;
                     if (line_rep >= ext_x) begin
                        line_rep = 0;
                        glyph_col++;
                        last = (glyph_col >= GLYPH_COLUMNS);
                     end
                  end
               end
            end else begin
               rect_row++;
               if (rect_row >= ext_y) begin
                  rect_row = 0;
                  rect_col++;
                  last = (rect_col >= ext_x);
               end
            end
         end
      end
      if (last) begin
         wr_kind = KIND_IDLE;
         restart_counters();
      end
      lcd_bytes_due.push_back('{out_byte, cmd, last, 1'b0});
   endtask

   // Offer queued requests in bursts, predicting each one as it is taken
   always @(posedge clock) begin : req_side
      bit taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken) predict_lcd_bytes(cur_req);
         if (!req_tvalid || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (draw_queue.size() != 0 &&
                         !(draw_queue[0].wait_drain && lcd_bytes_due.size() != 0)) begin
               cur_req = draw_queue.pop_front();
               req_tuser <= cur_req.op;
               req_tdata <= {cur_req.rgb, cur_req.height, cur_req.width, cur_req.code,
                             cur_req.y_pos, cur_req.x_pos};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check each taken result item, then pick the next ready level
   always @(posedge clock) begin : rsp_side
      lcd_byte_type seen, due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
            if (lcd_bytes_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected item: expected none, got %s%h cmd=%b last=%b rej=%b",
                        $time, "data=", seen.data, seen.cmd, seen.last, seen.rej);
            end else begin
               due = lcd_bytes_due.pop_front();
               if (seen !== due) begin
                  errors++;
                  $display("%0t: item mismatch: expected data=%h cmd=%b last=%b rej=%b,",
                           $time, due.data, due.cmd, due.last, due.rej);
                  $display("%0t:    got data=%h cmd=%b last=%b rej=%b",
                           $time, seen.data, seen.cmd, seen.last, seen.rej);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         stall_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((stall_cycle / 200) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ((stall_cycle % 5) >= 2);
               default: rsp_tready <= ($urandom_range(0, 9) >= 4);
            endcase
         end
      end
   end

   function automatic logic [15:0] any16();
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_code();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(FIRST_CHAR, LAST_CHAR));
   endfunction

   function automatic int job_bytes(input logic [1:0] op, input logic [15:0] w, h);
      if (op == OP_GLYPH) return STEP_PIXELS + 80 * scale_reg * scale_reg;
      if (w == 0 || h == 0) return STEP_PIXELS;
      return STEP_PIXELS + 2 * w * h;
   endfunction

   task automatic push_req(input logic [1:0] op, input logic [15:0] x, y,
                           input logic [7:0] code, input logic [15:0] w, h, rgb);
      lcd_request_type rq;
      rq = '{op, x, y, code, w, h, rgb, 1'b0};
      draw_queue.push_back(rq);
   endtask

   // Ticks carry random payload that the block must ignore
   task automatic push_ticks(input int n);
      repeat (n) push_req(OP_TICK, any16(), any16(), 8'($urandom), any16(), any16(), any16());
   endtask

   task automatic push_job(input logic [1:0] op, input logic [15:0] x, y,
                           input logic [7:0] code, input logic [15:0] w, h, rgb);
      push_req(op, x, y, code, w, h, rgb);
      push_ticks(job_bytes(op, w, h));
   endtask

   // Mostly whole jobs with random content, some broken and some noise
   task automatic plan_random_phase(input int budget);
      int made, n, cut, stray;
      logic [1:0]  op;
      logic [15:0] w, h;
      made = 0;
      while (made < budget) begin
         op = ($urandom_range(0, 1) == 0) ? OP_GLYPH : OP_RECT;
         w = 16'($urandom_range(0, 4));
         h = 16'($urandom_range(0, 4));
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: push_req(OP_UNUSED, any16(), any16(), pick_code(), any16(), any16(), any16());
               1: push_ticks(1);
               default: push_req(op, any16(), any16(), pick_code(), w, h, any16());
            endcase
            made++;
         end else begin
            // one huge side and the other zero gives a header-only job
            if (op == OP_RECT && $urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  w = any16();
                  h = '0;
               end else begin
                  w = '0;
                  h = any16();
               end
            end
            n = job_bytes(op, w, h);
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0;
            stray = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : 0;
            push_req(op, any16(), any16(), pick_code(), w, h, any16());
            for (int i = 1; i <= n - cut; i++) begin
               if (i == stray)
                  push_req(op ^ 2'd1, any16(), any16(), pick_code(), 16'd2, 16'd2, any16());
               push_ticks(1);
            end
            made += n + 1 - cut;
         end
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FONT_COLOR: fg_rgb = value;
         CSR_BACK_COLOR: bg_rgb = value;
         CSR_FONT_SCALE: scale_reg = value[3:0];
         default: ;
      endcase
   endtask

   // Wait until every queued item is taken and every byte has come back
   task automatic settle();
      do @(posedge clock);
      while (draw_queue.size() != 0 || req_tvalid || lcd_bytes_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [3:0] scale_pick [RANDOM_PHASES] = '{4'd1, 4'd2, 4'd1, 4'd0, 4'd1, 4'd1, 4'd0, 4'd1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle ticks, empty windows, wrap, busy rejects, glyph code edges
      push_ticks(1);
      push_req(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_job(OP_RECT, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'hFFFF, 16'h1234);
      push_job(OP_RECT, 16'hFFFF, 16'h8000, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF);
      push_req(OP_RECT, 16'hFFFF, 16'hFFFF, 8'h00, 16'h0001, 16'h0001, 16'hA55A);
      push_ticks(3);
      push_req(OP_GLYPH, 16'h0001, 16'h0002, 8'h41, 16'h0000, 16'h0000, 16'h0000);
      push_req(OP_RECT, 16'h0003, 16'h0004, 8'h00, 16'h0001, 16'h0001, 16'h0F0F);
      push_ticks(11);
      push_job(OP_RECT, 16'h0100, 16'h00FF, 8'h00, 16'h0002, 16'h0003, 16'h0000);
      push_job(OP_GLYPH, 16'h0000, 16'h0000, 8'h1F, '0, '0, '0);
      push_job(OP_GLYPH, 16'h0123, 16'h0456, 8'h20, '0, '0, '0);
      push_job(OP_GLYPH, 16'h8000, 16'h7FFF, 8'h7F, '0, '0, '0);
      push_job(OP_GLYPH, 16'h00F0, 16'h000F, 8'h80, '0, '0, '0);
      push_job(OP_GLYPH, 16'hFFFF, 16'hFFFA, 8'h00, '0, '0, '0);
      push_job(OP_GLYPH, 16'h0010, 16'h0020, 8'h41, '0, '0, '0);
      settle();

      // Inverted colors at scale two, near the top of the address range
      write_csr(CSR_FONT_COLOR, 16'h0000);
      write_csr(CSR_BACK_COLOR, 16'hFFFF);
      write_csr(CSR_FONT_SCALE, 16'h0002);
      push_job(OP_GLYPH, 16'hFFFC, 16'hFFF8, 8'h7E, '0, '0, '0);
      settle();

      // Scale zero: glyph jobs end on the memory write command
      write_csr(CSR_FONT_SCALE, 16'hFFF0);
      push_req(OP_GLYPH, 16'h1234, 16'h4321, 8'h41, '0, '0, '0);
      push_ticks(4);
      push_req(OP_RECT, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001, 16'h0001);
      push_ticks(7);
      push_req(OP_UNUSED, '0, '0, '0, '0, '0, '0);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_csr(CSR_FONT_COLOR, any16());
         write_csr(CSR_BACK_COLOR, any16());
         write_csr(CSR_FONT_SCALE, {12'($urandom), scale_pick[ph]});
         plan_random_phase(PHASE_ITEMS);
         // stall the result side long enough to back up the request side
         if (ph == 2) hold_requests++;
         if (ph == 5) draw_queue[draw_queue.size() / 2].wait_drain = 1'b1;
         settle();
      end

      // Close any job a broken sequence left open
      while (wr_kind != KIND_IDLE) begin
         push_ticks(1);
         settle();
      end

      // Largest scale: header window and the first part of the pixels
      write_csr(CSR_FONT_SCALE, 16'h000F);
      write_csr(CSR_FONT_COLOR, 16'hF800);
      write_csr(CSR_BACK_COLOR, 16'h07E0);
      push_req(OP_GLYPH, 16'hFFA0, 16'hFFC0, 8'h57, '0, '0, '0);
      push_ticks(60);
      push_req(OP_RECT, 16'h0000, 16'h0000, 8'h00, 16'h0001, 16'h0001, 16'h0000);
      push_ticks(100);
      settle();
      repeat (10) @(posedge clock);

      if (errors == 0 && lcd_bytes_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sgw_pkg.sv
rtl/scaled_glyph_and_fill_lcd_writer.sv
rtl/sgw_checker.sv
test/tb_scaled_glyph_and_fill_lcd_writer.sv
